### sv/lbcd_pkg.sv
// Package for the literal byte character decoder.
// Holds the decoder state types, byte constants and the small lookup functions.
// No dependencies.
`default_nettype none

package lbcd_pkg;

   localparam logic [7:0] BYTE_BACKSLASH = 8'h5c;
   localparam logic [7:0] BYTE_LETTER_X  = 8'h78;
   localparam logic [7:0] BYTE_ESC       = 8'h1b;
   localparam logic [7:0] BYTE_DOLLAR    = 8'h24;
   localparam logic [7:0] BYTE_LETTER_B  = 8'h42;
   localparam logic [7:0] BYTE_PAREN     = 8'h28;
   localparam logic [7:0] BYTE_EUC_SS2   = 8'h8e;
   localparam logic [7:0] EUC_LEAD_LOW   = 8'ha1;
   localparam logic [7:0] EUC_LEAD_HIGH  = 8'hfe;
   localparam logic [7:0] SJIS_LOW_A     = 8'd129;
   localparam logic [7:0] SJIS_HIGH_A    = 8'd159;
   localparam logic [7:0] SJIS_LOW_B     = 8'd224;
   localparam logic [7:0] SJIS_HIGH_B    = 8'd239;

   localparam logic [1:0] HEX_IDLE = 2'd0;
   localparam logic [1:0] HEX_OPEN = 2'd1;
   localparam logic [1:0] HEX_ONE  = 2'd2;
   localparam logic [1:0] HEX_TWO  = 2'd3;

   typedef enum logic [2:0] {
      JIS_OUT,
      JIS_ESC,
      JIS_ESC_DOLLAR,
      JIS_SHIFTED,
      JIS_HELD,
      JIS_SH_ESC,
      JIS_SH_ESC_PAREN
   } jis_phase_type;

   typedef enum logic [1:0] {
      EUC_IDLE,
      EUC_PREFIX,
      EUC_LEAD
   } euc_phase_type;

   typedef struct packed {
      logic          escape_pending;
      logic [1:0]    hex_digit_count;
      logic [7:0]    held_byte;
      logic          sjis_lead_seen;
      jis_phase_type jis_phase;
      euc_phase_type euc_phase;
   } dec_state_type;

   typedef struct packed {
      logic        emit;
      logic [15:0] char_code;
      logic        malformed;
   } dec_result_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         v = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

   function automatic logic [7:0] escape_value(input logic [7:0] c);
      logic [7:0] v;
      case (c)
         8'h6e: v = 8'd10;
         8'h74: v = 8'd9;
         8'h72: v = 8'd13;
         8'h61: v = 8'd7;
         8'h62: v = 8'd8;
         8'h66: v = 8'd12;
         8'h76: v = 8'd11;
         default: begin
            if (c inside {[8'h30:8'h37]}) begin
               v = {5'd0, c[2:0]};
            end else begin
               v = c;
            end
         end
      endcase
      return v;
   endfunction

   function automatic logic is_sjis_lead(input logic [7:0] c);
      return (c inside {[SJIS_LOW_A:SJIS_HIGH_A], [SJIS_LOW_B:SJIS_HIGH_B]});
   endfunction

endpackage

`default_nettype wire

### sv/lbcd_decode.sv
// Next-state and result logic of the literal byte character decoder.
// Purely combinational; depends on lbcd_pkg.
`default_nettype none

module lbcd_decode
   import lbcd_pkg::*;
(
   input  var dec_state_type  cur_state,
   input  var logic [7:0]     in_byte,
   input  var logic           wide_mode,
   output dec_state_type      nxt_state,
   output dec_result_type     result
);

   logic          c_hex;
   logic          hex_first;
   logic [1:0]    hex_count1;
   jis_phase_type jis1;
   logic [15:0]   code;
   logic          bad;

   assign c_hex      = is_hex(in_byte);
   assign hex_first  = (cur_state.hex_digit_count == HEX_OPEN) && c_hex;
   assign hex_count1 = ((cur_state.hex_digit_count != HEX_IDLE) && c_hex &&
                        (cur_state.hex_digit_count != HEX_TWO)) ?
                       cur_state.hex_digit_count + 2'd1 : cur_state.hex_digit_count;
   assign jis1       = (cur_state.jis_phase == JIS_HELD) ? JIS_SHIFTED : cur_state.jis_phase;

   always_comb begin
      nxt_state = cur_state;
      code      = 16'd0;
      bad       = 1'b0;
      result    = '0;
      if (in_byte == BYTE_BACKSLASH && !cur_state.escape_pending) begin
         nxt_state.escape_pending = 1'b1;
      end else if (cur_state.escape_pending && in_byte == BYTE_LETTER_X) begin
         nxt_state.hex_digit_count = HEX_OPEN;
         nxt_state.escape_pending  = 1'b0;
      end else begin
         nxt_state.hex_digit_count = hex_count1;
         if (hex_first) begin
            nxt_state.held_byte = in_byte;
         end else if (!cur_state.sjis_lead_seen && is_sjis_lead(in_byte)) begin
            nxt_state.sjis_lead_seen = 1'b1;
            nxt_state.held_byte      = in_byte;
         end else if (cur_state.jis_phase == JIS_OUT && in_byte == BYTE_ESC) begin
            nxt_state.jis_phase = JIS_ESC;
         end else if (cur_state.jis_phase == JIS_ESC && in_byte == BYTE_DOLLAR) begin
            nxt_state.jis_phase = JIS_ESC_DOLLAR;
         end else if (cur_state.jis_phase == JIS_ESC_DOLLAR && in_byte == BYTE_LETTER_B) begin
            nxt_state.jis_phase = JIS_SHIFTED;
         end else if (cur_state.jis_phase == JIS_SHIFTED) begin
            if (in_byte == BYTE_ESC) begin
               nxt_state.jis_phase = JIS_SH_ESC;
            end else begin
               nxt_state.held_byte = in_byte;
               nxt_state.jis_phase = JIS_HELD;
            end
         end else if (jis1 == JIS_SH_ESC && in_byte == BYTE_PAREN) begin
            nxt_state.jis_phase = JIS_SH_ESC_PAREN;
         end else if (jis1 == JIS_SH_ESC_PAREN && in_byte == BYTE_LETTER_B) begin
            nxt_state.jis_phase = JIS_OUT;
         end else begin
            nxt_state.jis_phase = jis1;
            if (!cur_state.sjis_lead_seen && cur_state.euc_phase == EUC_IDLE &&
                in_byte == BYTE_EUC_SS2) begin
               nxt_state.euc_phase = EUC_PREFIX;
            end else if (!cur_state.sjis_lead_seen && cur_state.euc_phase == EUC_IDLE &&
                         (in_byte inside {[EUC_LEAD_LOW:EUC_LEAD_HIGH]})) begin
               nxt_state.held_byte = in_byte;
               nxt_state.euc_phase = EUC_LEAD;
            end else begin
               result.emit = 1'b1;
               if (cur_state.escape_pending) begin
                  code = {8'd0, escape_value(in_byte)};
                  nxt_state.escape_pending = 1'b0;
               end else if (hex_count1 != HEX_IDLE) begin
                  if (hex_count1 == HEX_TWO && c_hex) begin
                     code = {8'd0, hex_value(cur_state.held_byte), hex_value(in_byte)};
                  end else begin
                     bad = 1'b1;
                  end
                  nxt_state.hex_digit_count = HEX_IDLE;
               end else if (cur_state.sjis_lead_seen) begin
                  code = {cur_state.held_byte, in_byte};
                  nxt_state.sjis_lead_seen = 1'b0;
               end else if (jis1 == JIS_SHIFTED) begin
                  code = {cur_state.held_byte, in_byte};
               end else if (cur_state.euc_phase == EUC_PREFIX) begin
                  code = {8'd0, in_byte};
                  nxt_state.euc_phase = EUC_IDLE;
               end else if (cur_state.euc_phase == EUC_LEAD) begin
                  code = {cur_state.held_byte, in_byte};
                  nxt_state.euc_phase = EUC_IDLE;
               end else begin
                  code = {8'd0, in_byte};
               end
               result.char_code = wide_mode ? code : {8'd0, code[7:0]};
               result.malformed = bad;
            end
         end
      end
   end

endmodule

`default_nettype wire

### sv/literal_byte_char_decoder.sv
// Literal byte character decoder, top level.
// An accepted byte is registered at the input, decoded, and its character registered for the result port.
// Throughput: one byte per cycle while the result port is not stalled; the decode state loop holds a single register.
// Synchronous active-high reset clears all decode state, wide_mode and both stages.
// Depends on lbcd_pkg and lbcd_decode.
`default_nettype none

module literal_byte_char_decoder
   import lbcd_pkg::*;
(
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_tvalid,
   output logic            req_tready,
   input  var logic [7:0]  req_tdata,    // [7:0] in_byte
   output logic            rsp_tvalid,
   input  var logic        rsp_tready,
   output logic [15:0]     rsp_tdata,    // [15:0] char_code
   output logic            rsp_tuser,    // [0] malformed
   input  var logic        csr_valid,
   output logic            csr_ready,
   input  var logic        csr_wdata     // wide_mode
);

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic [15:0]    out_code_ff;
   logic           out_bad_ff;
   logic           wide_mode_ff;
   dec_state_type  state_ff;
   dec_state_type  state_in;
   dec_result_type result;
   logic           out_free;
   logic           advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   lbcd_decode u_decode (
      .cur_state (state_ff),
      .in_byte   (in_byte_ff),
      .wide_mode (wide_mode_ff),
      .nxt_state (state_in),
      .result    (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (advance && result.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         wide_mode_ff <= 1'b0;
         state_ff     <= '{escape_pending: 1'b0, hex_digit_count: HEX_IDLE,
                           held_byte: 8'd0, sjis_lead_seen: 1'b0,
                           jis_phase: JIS_OUT, euc_phase: EUC_IDLE};
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            wide_mode_ff <= csr_wdata;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && result.emit) begin
         out_code_ff <= result.char_code;
         out_bad_ff  <= result.malformed;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_code_ff;
   assign rsp_tuser  = out_bad_ff;

   // A malformed hex escape always carries a zero character code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 16'd0)
      else $error("malformed result with nonzero code");

   // A byte in the input register that cannot advance is held unchanged.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input byte lost or changed");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

### tb/literal_byte_char_decoder_checker.sv
// Checker for the literal byte character decoder: watches the byte, character and mode
// channels, predicts every decoded character and compares it with what the block sends.
// Depends on lbcd_pkg.
`default_nettype none

module literal_byte_char_decoder_checker
   import lbcd_pkg::*;
(
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_tvalid,
   input  var logic        req_tready,
   input  var logic [7:0]  req_tdata,    // [7:0] in_byte
   input  var logic        rsp_tvalid,
   input  var logic        rsp_tready,
   input  var logic [15:0] rsp_tdata,    // [15:0] char_code
   input  var logic        rsp_tuser,    // [0] malformed
   input  var logic        csr_valid,
   input  var logic        csr_ready,
   input  var logic        csr_wdata,
   output int              error_count,
   output int              pending_count,
   output int              char_count
);

   typedef struct packed {
      logic [15:0] char_code;
      logic        malformed;
   } char_item_type;

   char_item_type expected_chars[$];
   logic          wide_mode;
   logic          escape_pending;
   logic [1:0]    hex_digit_count;
   logic [7:0]    held_byte;
   logic          sjis_lead_seen;
   jis_phase_type jis_phase;
   euc_phase_type euc_phase;

   function automatic logic hex_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
      end
      return d[3:0];
   endfunction

   // Advances the decode state by one byte and returns the character it finishes, if any.
   function automatic dec_result_type decode_byte(input logic [7:0] c);
      dec_result_type r;
      logic [15:0]    code;
      r = '0;
      code = 16'd0;
      if (c == BYTE_BACKSLASH && !escape_pending) begin
         escape_pending = 1'b1;
         return r;
      end
      if (escape_pending && c == BYTE_LETTER_X) begin
         hex_digit_count = HEX_OPEN;
         escape_pending = 1'b0;
         return r;
      end
      if (hex_digit_count != HEX_IDLE && hex_char(c)) begin
         if (hex_digit_count != HEX_TWO) hex_digit_count = hex_digit_count + 2'd1;
         if (hex_digit_count == HEX_ONE) begin
            held_byte = c;
            return r;
         end
      end
      if (!sjis_lead_seen && ((c >= SJIS_LOW_A && c <= SJIS_HIGH_A) ||
                              (c >= SJIS_LOW_B && c <= SJIS_HIGH_B))) begin
         sjis_lead_seen = 1'b1;
         held_byte = c;
         return r;
      end
      if (jis_phase == JIS_OUT && c == BYTE_ESC) begin
         jis_phase = JIS_ESC;
         return r;
      end
      if (jis_phase == JIS_ESC && c == BYTE_DOLLAR) begin
         jis_phase = JIS_ESC_DOLLAR;
         return r;
      end
      if (jis_phase == JIS_ESC_DOLLAR && c == BYTE_LETTER_B) begin
         jis_phase = JIS_SHIFTED;
         return r;
      end
      if (jis_phase == JIS_SHIFTED) begin
         if (c == BYTE_ESC) begin
            jis_phase = JIS_SH_ESC;
         end else begin
            held_byte = c;
            jis_phase = JIS_HELD;
         end
         return r;
      end
      if (jis_phase == JIS_HELD) jis_phase = JIS_SHIFTED;
      if (jis_phase == JIS_SH_ESC && c == BYTE_PAREN) begin
         jis_phase = JIS_SH_ESC_PAREN;
         return r;
      end
      if (jis_phase == JIS_SH_ESC_PAREN && c == BYTE_LETTER_B) begin
         jis_phase = JIS_OUT;
         return r;
      end
      if (!sjis_lead_seen && euc_phase == EUC_IDLE && c == BYTE_EUC_SS2) begin
         euc_phase = EUC_PREFIX;
         return r;
      end
      if (!sjis_lead_seen && euc_phase == EUC_IDLE && c >= EUC_LEAD_LOW &&
          c <= EUC_LEAD_HIGH) begin
         held_byte = c;
         euc_phase = EUC_LEAD;
         return r;
      end

      r.emit = 1'b1;
      if (escape_pending) begin
         case (c)
            8'h6e: code = 16'd10;
            8'h74: code = 16'd9;
            8'h72: code = 16'd13;
            8'h61: code = 16'd7;
            8'h62: code = 16'd8;
            8'h66: code = 16'd12;
            8'h76: code = 16'd11;
            default: begin
               code = (c >= 8'h30 && c <= 8'h37) ? {13'd0, c[2:0]} : {8'd0, c};
            end
         endcase
         escape_pending = 1'b0;
      end else if (hex_digit_count != HEX_IDLE) begin
         if (hex_digit_count == HEX_TWO && hex_char(c)) begin
            code = {8'd0, hex_nibble(held_byte), hex_nibble(c)};
         end else begin
            r.malformed = 1'b1;
         end
         hex_digit_count = HEX_IDLE;
      end else if (sjis_lead_seen) begin
         code = {held_byte, c};
         sjis_lead_seen = 1'b0;
      end else if (jis_phase == JIS_SHIFTED) begin
         code = {held_byte, c};
      end else if (euc_phase == EUC_PREFIX) begin
         code = {8'd0, c};
         euc_phase = EUC_IDLE;
      end else if (euc_phase == EUC_LEAD) begin
         code = {held_byte, c};
         euc_phase = EUC_IDLE;
      end else begin
         code = {8'd0, c};
      end
      if (!wide_mode) code[15:8] = 8'd0;
      r.char_code = code;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      dec_result_type r;
      char_item_type  want;
      if (reset) begin
         expected_chars.delete();
         wide_mode = 1'b0;
         escape_pending = 1'b0;
         hex_digit_count = HEX_IDLE;
         held_byte = 8'd0;
         sjis_lead_seen = 1'b0;
         jis_phase = JIS_OUT;
         euc_phase = EUC_IDLE;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character transaction: char_code %h malformed %b",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               char_count++;
               if (rsp_tdata !== want.char_code) begin
                  $error("char_code mismatch: expected %h, actual %h",
                         want.char_code, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== want.malformed) begin
                  $error("malformed mismatch: expected %b, actual %b",
                         want.malformed, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) wide_mode = csr_wdata;
         if (req_tvalid && req_tready) begin
            r = decode_byte(req_tdata);
            if (r.emit) expected_chars.push_back('{r.char_code, r.malformed});
         end
      end
      pending_count <= expected_chars.size();
   end

endmodule

`default_nettype wire

### tb/literal_byte_char_decoder_test.sv
// Top of the literal byte character decoder test: clock, reset, byte and mode stimulus,
// random result backpressure, a watchdog and the final verdict.
// Depends on lbcd_pkg, literal_byte_char_decoder and literal_byte_char_decoder_checker.
`default_nettype none

module literal_byte_char_decoder_test
   import lbcd_pkg::*;
();

   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 4;
   localparam int PHASE_BYTES     = 270;
   localparam int PHASE_COUNT     = 5;
   localparam int DIRECTED_COUNT  = 25;
   localparam logic [8*DIRECTED_COUNT-1:0] DIRECTED_BYTES = {
      8'h00, 8'hff, 8'h5c, 8'h6e, 8'h5c, 8'h37, 8'h5c, 8'h78, 8'h41, 8'h66,
      8'h5c, 8'h78, 8'h7a, 8'h81, 8'h40, 8'h1b, 8'h24, 8'h42, 8'h30, 8'h21,
      8'h1b, 8'h28, 8'h42, 8'ha1, 8'hb2};
   localparam logic [55:0] ESCAPE_LETTERS = {
      8'h6e, 8'h74, 8'h72, 8'h61, 8'h62, 8'h66, 8'h76};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_ready;

   int   error_count;
   int   pending_count;
   int   char_count;
   int   bytes_sent;
   int   mode_writes;
   int   idle_cycles;
   int   hold_start;
   int   hold_seen;
   int   hold_left;
   logic calm = 1'b0;

   literal_byte_char_decoder dut (.*);

   literal_byte_char_decoder_checker chk (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_start) begin
         hold_seen <= hold_start;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 20);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("literal_byte_char_decoder_test: FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] value);
      if (!calm && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_writes++;
   endtask

   // Mostly well-formed characters with random content, plus some broken ones and noise.
   task automatic send_token();
      int         pick;
      int         count;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         b = 8'($urandom_range(8'h20, 8'h7e));
         if (b == BYTE_BACKSLASH) b = 8'h41;
         send_byte(b);
      end else if (pick < 30) begin
         send_byte(BYTE_BACKSLASH);
         case ($urandom_range(0, 2))
            0: send_byte(ESCAPE_LETTERS[8*$urandom_range(0, 6) +: 8]);
            1: send_byte(8'(8'h30 + $urandom_range(0, 7)));
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
      end else if (pick < 45) begin
         send_byte(BYTE_BACKSLASH);
         send_byte(BYTE_LETTER_X);
         count = $urandom_range(0, 5);
         count = (count < 4) ? 2 : count - 4;
         repeat (count) begin
            case ($urandom_range(0, 2))
               0: send_byte(8'(8'h30 + $urandom_range(0, 9)));
               1: send_byte(8'(8'h41 + $urandom_range(0, 5)));
               default: send_byte(8'(8'h61 + $urandom_range(0, 5)));
            endcase
         end
         if (count < 2) send_byte(8'($urandom_range(8'h67, 8'h7a)));
      end else if (pick < 60) begin
         if ($urandom_range(0, 1)) send_byte(8'($urandom_range(SJIS_LOW_A, SJIS_HIGH_A)));
         else send_byte(8'($urandom_range(SJIS_LOW_B, SJIS_HIGH_B)));
         send_byte(8'($urandom_range(8'h40, 8'hfc)));
      end else if (pick < 72) begin
         if ($urandom_range(0, 1)) send_byte(8'($urandom_range(8'ha1, 8'hdf)));
         else send_byte(8'($urandom_range(8'hf0, EUC_LEAD_HIGH)));
         send_byte(8'($urandom_range(EUC_LEAD_LOW, EUC_LEAD_HIGH)));
      end else if (pick < 82) begin
         send_byte(BYTE_ESC);
         if ($urandom_range(0, 4) == 0) begin
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_byte(BYTE_DOLLAR);
            send_byte(BYTE_LETTER_B);
            repeat (2 * $urandom_range(1, 4)) send_byte(8'($urandom_range(8'h21, 8'h7e)));
            send_byte(BYTE_ESC);
            send_byte(BYTE_PAREN);
            send_byte(BYTE_LETTER_B);
         end
      end else begin
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int   phase;
      int   target;
      logic held_off;
      logic paused;
      held_off = 1'b0;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b1);
      for (int k = 0; k < DIRECTED_COUNT; k++) begin
         send_byte(DIRECTED_BYTES[8*(DIRECTED_COUNT-1-k) +: 8]);
      end
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         write_mode(phase[0]);
         calm = (phase == 1);
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            if (phase == 2 && !held_off && bytes_sent >= target - PHASE_BYTES / 2) begin
               held_off = 1'b1;
               hold_start++;
               repeat (40) send_byte(8'($urandom_range(8'h20, 8'h5b)));
            end
            if (phase == 3 && !paused && bytes_sent >= target - PHASE_BYTES / 2) begin
               paused = 1'b1;
               repeat (3) begin
                  wait_drained();
                  send_byte(8'($urandom_range(8'h20, 8'h5b)));
               end
            end
            send_token();
         end
         calm = 1'b0;
      end
      wait_drained();
      $display("Sent %0d bytes, checked %0d characters across %0d wide/narrow mode writes,",
               bytes_sent, char_count, mode_writes);
      $display("including escapes, hex, Shift-JIS, JIS, EUC, noise and a long result stall.");
      if (error_count == 0) begin
         $display("literal_byte_char_decoder_test: PASS");
      end else begin
         $display("literal_byte_char_decoder_test: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
